### hdl/gsp_pkg.sv
`timescale 1ns / 1ps
package gsp_pkg;

  // work carried from the front part to the back part
  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_PRED_DIR = 3'd1,
    OP_PRED_TGT = 3'd2,
    OP_UPD_DIR  = 3'd3,
    OP_UPD_TGT  = 3'd4
  } op_t;

  typedef struct packed {
    op_t  op;
    logic taken;
  } cmd_t;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // saturation limits of the signed 2-bit direction counters
  localparam logic [1:0] CNT_MAX = 2'b01;
  localparam logic [1:0] CNT_MIN = 2'b10;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_ISSUE = 3'b010,
    ST_EXEC  = 3'b100
  } bstate_t;

endpackage

### hdl/gsp_front.sv
`timescale 1ns / 1ps
module gsp_front #(
  parameter int HB = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [63:0]       in_pc,
  input  logic              in_is_conditional,
  input  logic              in_is_indirect,
  input  logic              in_is_branch,
  input  logic              in_taken,
  input  logic [63:0]       in_actual_target,
  input  logic              init_done,
  input  logic              q_full,
  output logic              q_push,
  output gsp_pkg::cmd_t     q_cmd,
  output logic [HB-1:0]     q_idx,
  output logic [63:0]       q_target
);
  import gsp_pkg::*;

  logic          mode_r, mode_nxt;
  logic [HB-1:0] fet_hist_r, fet_hist_nxt;
  logic [HB-1:0] ret_hist_r, ret_hist_nxt;
  logic [HB-1:0] hist_sel;
  logic [HB-1:0] hist_upd;
  logic          any_branch;
  logic          accept;

  assign in_ready = init_done && !q_full;
  assign accept   = in_valid && in_ready;

  assign any_branch = in_is_conditional || in_is_indirect || in_is_branch;
  assign hist_sel   = in_mode ? ret_hist_r : fet_hist_r;
  assign q_idx      = hist_sel ^ in_pc[HB-1:0];
  assign q_target   = in_actual_target;

  always_comb begin
    q_cmd.taken = in_taken;
    q_cmd.op    = OP_NONE;
    if (!mode_r && in_is_conditional) begin
      q_cmd.op = in_mode ? OP_UPD_DIR : OP_PRED_DIR;
    end else if (mode_r && in_is_indirect) begin
      q_cmd.op = in_mode ? OP_UPD_TGT : OP_PRED_TGT;
    end
  end

  assign q_push = accept && (q_cmd.op != OP_NONE);

  // conditional shifts in its outcome, any other branch a one
  always_comb begin
    hist_upd = hist_sel;
    if (in_is_conditional) begin
      hist_upd = {hist_sel[HB-2:0], in_taken};
    end else if (any_branch) begin
      hist_upd = {hist_sel[HB-2:0], 1'b1};
    end
  end

  always_comb begin
    mode_nxt     = cfg_wr_en ? cfg_wr_data : mode_r;
    fet_hist_nxt = fet_hist_r;
    ret_hist_nxt = ret_hist_r;
    if (accept && !in_mode) begin
      fet_hist_nxt = hist_upd;
    end
    if (accept && in_mode) begin
      ret_hist_nxt = hist_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      fet_hist_r <= '0;
      ret_hist_r <= '0;
    end else begin
      mode_r     <= mode_nxt;
      fet_hist_r <= fet_hist_nxt;
      ret_hist_r <= ret_hist_nxt;
    end
  end

endmodule

### hdl/gsp_queue.sv
`timescale 1ns / 1ps
module gsp_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  import gsp_pkg::*;

  logic [W-1:0]      mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

### hdl/gsp_back.sv
`timescale 1ns / 1ps
module gsp_back #(
  parameter int CIB = 18,
  parameter int TIB = 14,
  parameter int HB  = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  gsp_pkg::cmd_t q_cmd,
  input  logic [HB-1:0] q_idx,
  input  logic [63:0]   q_target,
  output logic          q_pop,
  output logic          init_done,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_predict_taken,
  output logic [63:0]   out_predict_target
);
  import gsp_pkg::*;

  logic [1:0]  cnt_mem [2**CIB];
  logic [63:0] tgt_mem [2**TIB];

  bstate_t       state_r, state_nxt;
  logic [HB-1:0] clr_r, clr_nxt;
  cmd_t          cmd_r;
  logic [HB-1:0] idx_r;
  logic [63:0]   tgt_r;
  logic [1:0]    rd_cnt_r;
  logic [63:0]   rd_tgt_r;
  logic          out_valid_r, out_valid_nxt;
  logic          out_taken_r;
  logic [63:0]   out_target_r;

  logic          clearing, exec, is_pred, out_free, load;
  logic          cnt_we, tgt_we;
  logic [CIB-1:0] cnt_wa;
  logic [TIB-1:0] tgt_wa;
  logic [1:0]    cnt_wd, cnt_step;
  logic [63:0]   tgt_wd;

  assign clearing  = (state_r == ST_CLEAR);
  assign exec      = (state_r == ST_EXEC);
  assign init_done = !clearing;
  assign q_pop     = (state_r == ST_ISSUE) && !q_empty;
  assign is_pred   = (cmd_r.op == OP_PRED_DIR) || (cmd_r.op == OP_PRED_TGT);
  assign out_free  = !out_valid_r || out_ready;
  assign load      = exec && is_pred && out_free;

  // saturating step toward the outcome
  always_comb begin
    cnt_step = rd_cnt_r;
    if (cmd_r.taken && rd_cnt_r != CNT_MAX) begin
      cnt_step = rd_cnt_r + 2'd1;
    end else if (!cmd_r.taken && rd_cnt_r != CNT_MIN) begin
      cnt_step = rd_cnt_r - 2'd1;
    end
  end

  assign cnt_we = clearing || (exec && cmd_r.op == OP_UPD_DIR);
  assign cnt_wa = clearing ? clr_r[CIB-1:0] : idx_r[CIB-1:0];
  assign cnt_wd = clearing ? 2'd0 : cnt_step;
  assign tgt_we = clearing || (exec && cmd_r.op == OP_UPD_TGT);
  assign tgt_wa = clearing ? clr_r[TIB-1:0] : idx_r[TIB-1:0];
  assign tgt_wd = clearing ? 64'd0 : tgt_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (!q_empty) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!is_pred || out_free) begin
          state_nxt = ST_ISSUE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
      idx_r <= q_idx;
      tgt_r <= q_target;
    end
    if (load) begin
      out_taken_r  <= (cmd_r.op == OP_PRED_DIR) ? ~rd_cnt_r[1] : 1'b0;
      out_target_r <= (cmd_r.op == OP_PRED_TGT) ? rd_tgt_r : 64'd0;
    end
  end

  // direction counters, read once per popped command
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (q_pop) begin
      rd_cnt_r <= cnt_mem[q_idx[CIB-1:0]];
    end
  end

  // target table
  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tgt_wa] <= tgt_wd;
    end
    if (q_pop) begin
      rd_tgt_r <= tgt_mem[q_idx[TIB-1:0]];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_predict_taken  = out_taken_r;
  assign out_predict_target = out_target_r;

`ifndef SYNTHESIS
  a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!q_pop && !out_valid_r))
    else $error("command taken during table clear");
  a_pop_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> exec)
    else $error("popped command not executed");
  a_update_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && !is_pred) |=> (state_r == ST_ISSUE))
    else $error("update held in execute");
`endif

endmodule

### hdl/gshare_and_indirect_branch_predictor.sv
`timescale 1ns / 1ps
// gshare direction predictor with an indirect target predictor
//
// in_* channel: one micro-op per beat, fetch request (in_mode 0) or retire
//   update (in_mode 1); valid/ready handshake
// out_* channel: one prediction beat per fetch of a conditional branch in
//   direction mode, or of an indirect branch in target mode; retires and
//   other fetches give no beat
// cfg_*: cfg_wr_en writes predictor_mode from cfg_wr_data at once; the user
//   must write it only while the block is idle, the block does not enforce it
// a predicting fetch reaches out_valid through the queue write, the queue
//   pop with table read, then the output register, given an empty queue
// the back part handles one queued command at a time: table read on pop,
//   then table write or output load; the 4-entry queue lets the front
//   take a beat per cycle in bursts while it is not full, fetches with
//   nothing to do never enter the queue
// reset: histories and mode clear at once, then both tables are cleared
//   one entry per cycle over 2**max(COUNTER_INDEX_BITS, TARGET_INDEX_BITS)
//   indices, with in_ready low
// when out_ready is low the back part holds its result, the queue fills
//   and then in_ready drops
module gshare_and_indirect_branch_predictor #(
  parameter int COUNTER_INDEX_BITS = 18,
  parameter int TARGET_INDEX_BITS  = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [63:0] in_pc,
  input  logic        in_is_conditional,
  input  logic        in_is_indirect,
  input  logic        in_is_branch,
  input  logic        in_taken,
  input  logic [63:0] in_actual_target,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_predict_taken,
  output logic [63:0] out_predict_target
);
  import gsp_pkg::*;

  // histories are as wide as the wider of the two table indexes
  localparam int HB = (COUNTER_INDEX_BITS > TARGET_INDEX_BITS) ?
                      COUNTER_INDEX_BITS : TARGET_INDEX_BITS;
  localparam int QW = $bits(cmd_t) + HB + 64;

  logic          init_done;
  logic          q_full, q_empty, q_push, q_pop;
  cmd_t          f_cmd, b_cmd;
  logic [HB-1:0] f_idx, b_idx;
  logic [63:0]   f_target, b_target;
  logic [QW-1:0] q_wdata, q_rdata;

  // front: config register, histories, index forming, classification
  gsp_front #(
    .HB(HB)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_pc             (in_pc),
    .in_is_conditional (in_is_conditional),
    .in_is_indirect    (in_is_indirect),
    .in_is_branch      (in_is_branch),
    .in_taken          (in_taken),
    .in_actual_target  (in_actual_target),
    .init_done         (init_done),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (f_cmd),
    .q_idx             (f_idx),
    .q_target          (f_target)
  );

  assign q_wdata = {f_cmd, f_idx, f_target};

  // short command queue decoupling front and back
  gsp_queue #(
    .W(QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {b_cmd, b_idx, b_target} = q_rdata;

  // back: table memories, clear sweep, read-modify-write, output register
  gsp_back #(
    .CIB(COUNTER_INDEX_BITS),
    .TIB(TARGET_INDEX_BITS),
    .HB (HB)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_cmd              (b_cmd),
    .q_idx              (b_idx),
    .q_target           (b_target),
    .q_pop              (q_pop),
    .init_done          (init_done),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_predict_taken  (out_predict_taken),
    .out_predict_target (out_predict_target)
  );

endmodule
